// ===== hdl/attenuation_coef_interpolator_assert.svh =====
// Assertion macros for the attenuation coefficient interpolator
`ifndef ATTENUATION_COEF_INTERPOLATOR_ASSERT_SVH
`define ATTENUATION_COEF_INTERPOLATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ACI_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define ACI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/aci_pkg.sv =====
package aci_pkg;

   localparam int unsigned DIST_W  = 24;
   localparam int unsigned COEF_W  = 25;
   localparam int unsigned OFF_W   = 21;
   localparam int unsigned SPAN_W  = 21;
   localparam int unsigned HALF_W  = 20;
   localparam int unsigned K_W     = 36;
   localparam int unsigned K_LO_W  = 18;
   localparam int unsigned HK_W    = 22;
   localparam int unsigned FRAC    = 22;
   localparam int unsigned NUM_W   = 46;
   localparam int unsigned EST_W   = OFF_W + K_W;
   localparam int unsigned BRK_CNT = 12;
   localparam int unsigned SEG_CNT = BRK_CNT - 1;
   localparam int unsigned SEG_W   = 4;

   localparam logic [DIST_W-1:0] BRK_X [BRK_CNT] = '{
      24'd2867,   24'd5325,   24'd8192,   24'd13107,  24'd20480,  24'd26624,
      24'd40960,  24'd65536,  24'd81920,  24'd133120, 24'd245760, 24'd1331200
   };

   localparam logic [COEF_W-1:0] BRK_LIN [BRK_CNT] = '{
      25'd11744051, 25'd5872026, 25'd3690988, 25'd2348810, 25'd1509949, 25'd1174405,
      25'd754975,   25'd452985,  25'd369099,  25'd234881,  25'd117441,  25'd23488
   };

   localparam logic [COEF_W-1:0] BRK_QUAD [BRK_CNT] = '{
      25'd30198989, 25'd7381975, 25'd3355443, 25'd1174405, 25'd536871, 25'd285213,
      25'd125829,   25'd46976,   25'd31877,   25'd11744,   25'd3355,   25'd117
   };

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_BELOW = 2'd1,
      ST_ABOVE = 2'd2
   } status_type;

   // per-segment constants for one coefficient
   typedef struct packed {
      logic [K_W-1:0]    k;     // ceil(dy * 2^FRAC / span)
      logic [HK_W-1:0]   hk;    // ceil(half * 2^FRAC / span)
      logic [COEF_W-1:0] dy;
      logic [SPAN_W-1:0] span;
      logic [HALF_W-1:0] half;
      logic [COEF_W-1:0] y0;
   } seg_tab_type;

   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [SEG_W-1:0]  seg;
      logic [DIST_W-1:0] distance;
   } seg_out_type;

endpackage

// ===== hdl/aci_seg.sv =====
module aci_seg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       req_valid,
   input  logic [aci_pkg::DIST_W-1:0] req_distance,
   output aci_pkg::seg_out_type       seg_out
);
   import aci_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   status_type        status_ff;
   status_type        status_in;
   logic [SEG_W-1:0]  seg_ff;
   logic [SEG_W-1:0]  seg_in;
   logic [DIST_W-1:0] dist_ff;

   always_comb begin
      valid_in = req_valid;
      seg_in   = SEG_W'(SEG_CNT - 1);
      for (int i = SEG_CNT - 1; i >= 0; i--) begin
         if (req_distance <= BRK_X[i+1]) begin
            seg_in = SEG_W'(i);
         end
      end
      if (req_distance < BRK_X[0]) begin
         status_in = ST_BELOW;
      end else if (req_distance > BRK_X[BRK_CNT-1]) begin
         status_in = ST_ABOVE;
      end else begin
         status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status_ff <= status_in;
         seg_ff    <= seg_in;
         dist_ff   <= req_distance;
      end
   end

   assign seg_out = '{valid: valid_ff, status: status_ff, seg: seg_ff, distance: dist_ff};

endmodule

// ===== hdl/aci_lerp.sv =====
module aci_lerp (
   input  logic                       clock,
   input  logic                       adv,
   input  logic [aci_pkg::OFF_W-1:0]  off,
   input  aci_pkg::seg_tab_type       tab,
   input  logic                       clear,
   output logic [aci_pkg::COEF_W-1:0] coef
);
   import aci_pkg::*;

   localparam int unsigned K_HI_W = K_W - K_LO_W;

   // stage 2: products
   logic [OFF_W+K_HI_W-1:0] p_hi_ff, p_hi_in;
   logic [OFF_W+K_LO_W-1:0] p_lo_ff, p_lo_in;
   logic [NUM_W-1:0]        n2_ff, n2_in;
   logic [HK_W-1:0]         hk2_ff;
   logic [HALF_W-1:0]       half2_ff;
   logic [SPAN_W-1:0]       span2_ff;
   logic [COEF_W-1:0]       y02_ff;

   // stage 3: quotient estimate and numerator
   logic [EST_W-1:0]        est_sum;
   logic [COEF_W-1:0]       q3_ff, q3_in;
   logic [NUM_W-1:0]        n3_ff, n3_in;
   logic [SPAN_W-1:0]       span3_ff;
   logic [COEF_W-1:0]       y03_ff;

   // stage 4: back-multiply
   logic [NUM_W-1:0]        m4_ff, m4_in;
   logic [NUM_W-1:0]        n4_ff;
   logic [COEF_W-1:0]       q4_ff;
   logic [COEF_W-1:0]       y04_ff;

   // stage 5: correction
   logic [COEF_W-1:0]       q_fix;
   logic [COEF_W-1:0]       coef_ff, coef_in;

   always_comb begin
      p_hi_in = (OFF_W+K_HI_W)'(off) * (OFF_W+K_HI_W)'(tab.k[K_W-1:K_LO_W]);
      p_lo_in = (OFF_W+K_LO_W)'(off) * (OFF_W+K_LO_W)'(tab.k[K_LO_W-1:0]);
      n2_in   = NUM_W'(off) * NUM_W'(tab.dy);

      est_sum = (EST_W'(p_hi_ff) << K_LO_W) + EST_W'(p_lo_ff) + EST_W'(hk2_ff);
      q3_in   = est_sum[FRAC +: COEF_W];
      n3_in   = n2_ff + NUM_W'(half2_ff);

      m4_in   = NUM_W'(q3_ff) * NUM_W'(span3_ff);

      q_fix   = q4_ff - COEF_W'(m4_ff > n4_ff);
      coef_in = clear ? '0 : y04_ff - q_fix;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_hi_ff  <= p_hi_in;
         p_lo_ff  <= p_lo_in;
         n2_ff    <= n2_in;
         hk2_ff   <= tab.hk;
         half2_ff <= tab.half;
         span2_ff <= tab.span;
         y02_ff   <= tab.y0;

         q3_ff    <= q3_in;
         n3_ff    <= n3_in;
         span3_ff <= span2_ff;
         y03_ff   <= y02_ff;

         m4_ff    <= m4_in;
         n4_ff    <= n3_ff;
         q4_ff    <= q3_ff;
         y04_ff   <= y03_ff;

         coef_ff  <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

// ===== hdl/attenuation_coef_interpolator.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_distance
// rsp       out        rsp_valid/rsp_stall  rsp_status, rsp_linear_coef, rsp_quadratic_coef
//
// One request per cycle while the response is not stalled.
// Stages: segment search, products, estimate, back-multiply, rounding correction.
// Reset clears the valid bits only.
// A stalled response holds the whole pipeline; req_stall follows it.
`include "attenuation_coef_interpolator_assert.svh"

module attenuation_coef_interpolator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [aci_pkg::DIST_W-1:0] req_distance,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [aci_pkg::COEF_W-1:0] rsp_linear_coef,
   output logic [aci_pkg::COEF_W-1:0] rsp_quadratic_coef
);
   import aci_pkg::*;

   localparam int unsigned DEPTH = 4;

   logic              adv;
   seg_out_type       s1;
   seg_tab_type       lin_tab  [SEG_CNT];
   seg_tab_type       quad_tab [SEG_CNT];
   logic [DIST_W-1:0] off_full;
   logic [OFF_W-1:0]  off;
   logic [DEPTH-1:0]  vld_ff, vld_in;
   status_type        st_ff [DEPTH];
   logic              clear;

   for (genvar g = 0; g < SEG_CNT; g++) begin : g_tab
      localparam longint unsigned SPAN = BRK_X[g+1] - BRK_X[g];
      localparam longint unsigned HALF = SPAN / 2;
      localparam longint unsigned DYL  = BRK_LIN[g] - BRK_LIN[g+1];
      localparam longint unsigned DYQ  = BRK_QUAD[g] - BRK_QUAD[g+1];
      localparam longint unsigned KL   = ((DYL << FRAC) + SPAN - 1) / SPAN;
      localparam longint unsigned KQ   = ((DYQ << FRAC) + SPAN - 1) / SPAN;
      localparam longint unsigned HK   = ((HALF << FRAC) + SPAN - 1) / SPAN;

      assign lin_tab[g] = '{k: K_W'(KL), hk: HK_W'(HK), dy: COEF_W'(DYL),
                            span: SPAN_W'(SPAN), half: HALF_W'(HALF), y0: BRK_LIN[g]};
      assign quad_tab[g] = '{k: K_W'(KQ), hk: HK_W'(HK), dy: COEF_W'(DYQ),
                             span: SPAN_W'(SPAN), half: HALF_W'(HALF), y0: BRK_QUAD[g]};
   end

   assign adv       = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !adv;

   aci_seg u_seg (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .req_valid    (req_valid),
      .req_distance (req_distance),
      .seg_out      (s1)
   );

   assign off_full = s1.distance - BRK_X[s1.seg];
   assign off      = off_full[OFF_W-1:0];
   assign vld_in   = {vld_ff[DEPTH-2:0], s1.valid};
   assign clear    = st_ff[DEPTH-2] != ST_OK;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= s1.status;
         for (int i = 1; i < DEPTH; i++) begin
            st_ff[i] <= st_ff[i-1];
         end
      end
   end

   aci_lerp u_lin (
      .clock (clock),
      .adv   (adv),
      .off   (off),
      .tab   (lin_tab[s1.seg]),
      .clear (clear),
      .coef  (rsp_linear_coef)
   );

   aci_lerp u_quad (
      .clock (clock),
      .adv   (adv),
      .off   (off),
      .tab   (quad_tab[s1.seg]),
      .clear (clear),
      .coef  (rsp_quadratic_coef)
   );

   assign rsp_valid  = vld_ff[DEPTH-1];
   assign rsp_status = st_ff[DEPTH-1];

   `ACI_ASSERT_IMPL(a_err_zero, rsp_valid && rsp_status != ST_OK, rsp_linear_coef == '0 && rsp_quadratic_coef == '0, "error response with nonzero coefficient")
   `ACI_ASSERT_IMPL(a_lin_range, rsp_valid && rsp_status == ST_OK, rsp_linear_coef <= BRK_LIN[0] && rsp_linear_coef >= BRK_LIN[BRK_CNT-1], "linear coefficient outside table")
   `ACI_ASSERT_IMPL(a_quad_range, rsp_valid && rsp_status == ST_OK, rsp_quadratic_coef <= BRK_QUAD[0] && rsp_quadratic_coef >= BRK_QUAD[BRK_CNT-1], "quadratic coefficient outside table")
   `ACI_ASSERT_NEXT(a_stall_hold, rsp_valid && rsp_stall, rsp_valid && vld_ff == $past(vld_ff), "pipeline moved under stall")

endmodule
